/* sv/prw_pkg.sv */
// Shared types, codes and helpers for the packet word reassembler.
`timescale 1ns / 1ps
`default_nettype none

package prw_pkg;

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned CAP_W      = 13;
    localparam int unsigned EMPTY_W    = 2;
    localparam int unsigned INDEX_W    = 12;
    localparam int unsigned BYTES_W    = 15;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 13;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP     = 1'b1;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 13'd4096;
    localparam logic             SWAP_RESET     = 1'b1;

    typedef enum logic [1:0] {
        WS_DISCARD  = 2'd0,
        WS_STORED   = 2'd1,
        WS_COMPLETE = 2'd2
    } word_status_t;

    typedef struct packed {
        logic [CAP_W-1:0] capacity_words;
        logic             swap_bytes;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0]  word_data;
        logic               start_of_packet;
        logic               end_of_packet;
        logic [EMPTY_W-1:0] empty_bytes;
    } in_item_t;

    typedef struct packed {
        word_status_t       word_status;
        logic               overlong;
        logic [DATA_W-1:0]  stored_word;
        logic [INDEX_W-1:0] word_index;
        logic [BYTES_W-1:0] byte_count;
    } result_t;

    function automatic logic [DATA_W-1:0] byte_reverse(input logic [DATA_W-1:0] w);
        byte_reverse = {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

`default_nettype wire

/* sv/prw_cfg_regs.sv */
// Configuration registers of the packet word reassembler.
`timescale 1ns / 1ps
`default_nettype none

module prw_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [prw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [prw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output prw_pkg::cfg_t                        cfg
);

    prw_pkg::cfg_t cfg_reg;
    prw_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                prw_pkg::CFG_CAPACITY: cfg_next.capacity_words = cfg_wdata;
                prw_pkg::CFG_SWAP:     cfg_next.swap_bytes     = cfg_wdata[0];
                default:               cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.capacity_words <= prw_pkg::CAPACITY_RESET;
            cfg_reg.swap_bytes     <= prw_pkg::SWAP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* sv/prw_step.sv */
// Per-word deframing step: hunt, store, complete and overlong handling.
`timescale 1ns / 1ps
`default_nettype none

module prw_step #(
    parameter int unsigned MAX_WORDS = 4096,
    parameter int unsigned FILL_W    = 13
) (
    input  wire prw_pkg::cfg_t     cfg,
    input  wire prw_pkg::in_item_t item,
    input  wire logic [FILL_W-1:0] fill,
    output logic [FILL_W-1:0]   fill_next,
    output prw_pkg::result_t    res
);

    localparam int unsigned CMP_W   = (FILL_W > prw_pkg::CAP_W) ? FILL_W : prw_pkg::CAP_W;
    localparam int unsigned IDX_WW  = (FILL_W > prw_pkg::INDEX_W) ? FILL_W : prw_pkg::INDEX_W;
    localparam int unsigned BYTE_WW = (FILL_W + 2 > prw_pkg::BYTES_W) ? FILL_W + 2
                                                                       : prw_pkg::BYTES_W;
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_WORDS);

    logic [CMP_W-1:0]   cap_wide;
    logic [CMP_W-1:0]   cap_eff;
    logic               full;
    logic [FILL_W-1:0]  fill_base;
    logic [FILL_W-1:0]  fill_plus;
    logic               store;
    logic [IDX_WW-1:0]  idx_wide;
    logic [BYTE_WW-1:0] bytes_wide;

    always_comb
    begin
        // Clamp capacity to the range one to MAX_WORDS
        cap_wide = CMP_W'(cfg.capacity_words);
        if (cap_wide == '0)
            cap_eff = CMP_W'(1);
        else if (cap_wide > MAX_CMP)
            cap_eff = MAX_CMP;
        else
            cap_eff = cap_wide;

        // A word that arrives on a full packet abandons it and hunts again
        full      = (fill != '0) && (CMP_W'(fill) >= cap_eff);
        fill_base = full ? '0 : fill;
        fill_plus = fill_base + FILL_W'(1);
        store     = (fill_base != '0) || item.start_of_packet;

        idx_wide   = IDX_WW'(fill_base);
        bytes_wide = BYTE_WW'({fill_plus, 2'b00}) - BYTE_WW'(item.empty_bytes);

        res.word_status = prw_pkg::WS_DISCARD;
        res.overlong    = full;
        res.stored_word = '0;
        res.word_index  = '0;
        res.byte_count  = '0;
        fill_next       = fill_base;

        if (store)
        begin
            res.word_status = prw_pkg::WS_STORED;
            res.stored_word = cfg.swap_bytes ? prw_pkg::byte_reverse(item.word_data)
                                             : item.word_data;
            res.word_index  = idx_wide[prw_pkg::INDEX_W-1:0];
            fill_next       = fill_plus;
            if (item.end_of_packet)
            begin
                res.word_status = prw_pkg::WS_COMPLETE;
                res.byte_count  = bytes_wide[prw_pkg::BYTES_W-1:0];
                fill_next       = '0;
            end
        end
    end

endmodule

`default_nettype wire

/* sv/packet_word_reassembler_core.sv */
// Top level of the packet word reassembler: input register, step logic, result register.
// Each accepted item is held in the input register, and its result in the result register before it reaches the output.
// Throughput: one item per cycle while out_ready holds; the input and result registers let a new item enter
//   while a finished result still waits for out_ready.
// The fill index register and the step logic close one loop per item.
// Reset clears both valid flags and the fill index, capacity 4096, byte swapping on.
`timescale 1ns / 1ps
`default_nettype none

module packet_word_reassembler_core #(
    parameter int unsigned MAX_WORDS = 4096
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // input stream
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [prw_pkg::DATA_W-1:0]         word_data,
    input  wire logic                               start_of_packet,
    input  wire logic                               end_of_packet,
    input  wire logic [prw_pkg::EMPTY_W-1:0]        empty_bytes,
    // result stream
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [1:0]                              word_status,
    output logic                                    overlong,
    output logic [prw_pkg::DATA_W-1:0]              stored_word,
    output logic [prw_pkg::INDEX_W-1:0]             word_index,
    output logic [prw_pkg::BYTES_W-1:0]             byte_count,
    // configuration
    input  wire logic                               cfg_we,
    input  wire logic [prw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [prw_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    // Fill index counts up to MAX_WORDS inclusive
    localparam int unsigned FILL_W = $clog2(MAX_WORDS + 1);

    prw_pkg::cfg_t      cfg;
    prw_pkg::in_item_t  item_reg;
    prw_pkg::in_item_t  item_next;
    logic               item_valid_reg;
    logic               item_valid_next;
    prw_pkg::result_t   res_reg;
    prw_pkg::result_t   res_next;
    prw_pkg::result_t   step_res;
    logic               res_valid_reg;
    logic               res_valid_next;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic [FILL_W-1:0]  step_fill;
    logic               res_free;
    logic               proc_fire;
    logic               in_fire;

    prw_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    prw_step #(
        .MAX_WORDS (MAX_WORDS),
        .FILL_W    (FILL_W)
    ) u_step (
        .cfg       (cfg),
        .item      (item_reg),
        .fill      (fill_reg),
        .fill_next (step_fill),
        .res       (step_res)
    );

    // The result register frees up when empty or when its item is taken this cycle.
    // The held input item moves on whenever the result register frees up.
    always_comb
    begin
        res_free  = !res_valid_reg || out_ready;
        proc_fire = item_valid_reg && res_free;
        in_ready  = !item_valid_reg || res_free;
        in_fire   = in_valid && in_ready;

        item_next.word_data       = word_data;
        item_next.start_of_packet = start_of_packet;
        item_next.end_of_packet   = end_of_packet;
        item_next.empty_bytes     = empty_bytes;

        // Hold the input register unless a new item arrives; drop its valid once it moves on
        if (in_fire)
            item_valid_next = 1'b1;
        else if (proc_fire)
            item_valid_next = 1'b0;
        else
            item_valid_next = item_valid_reg;

        // Advance the fill index only when the step result is captured
        fill_next = proc_fire ? step_fill : fill_reg;
        res_next  = step_res;

        if (proc_fire)
            res_valid_next = 1'b1;
        else if (out_ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            fill_reg       <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
            fill_reg       <= fill_next;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= item_next;
        end
        if (proc_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = res_valid_reg;
    assign word_status = res_reg.word_status;
    assign overlong    = res_reg.overlong;
    assign stored_word = res_reg.stored_word;
    assign word_index  = res_reg.word_index;
    assign byte_count  = res_reg.byte_count;

`ifndef SYNTH
    // The fill index never runs past the largest packet
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(MAX_WORDS))
        else $error("fill index beyond MAX_WORDS");

    // A completed packet returns the block to hunting
    assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && (step_res.word_status == prw_pkg::WS_COMPLETE) |=> fill_reg == '0)
        else $error("fill index not cleared after packet end");

    // Overlong can only be flagged while a packet is open
    assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && step_res.overlong |-> fill_reg != '0)
        else $error("overlong flagged while hunting");

    // Back-pressure on the input only when both registers hold items and the output stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> item_valid_reg && res_valid_reg && !out_ready)
        else $error("input stalled without cause");

    // The fill index moves only when an item passes through the step logic
    assert property (@(posedge clk) disable iff (!rst_n)
        !proc_fire |=> $stable(fill_reg))
        else $error("fill index changed without an item");
`endif

endmodule

`default_nettype wire
